// ===== hw/rtl/tlnef_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlnef_pkg
// Shared types and constants of the text line number and escape filter.
// ----------------------------------------------------------------------------
package tlnef_pkg;

    localparam int NUMBER_DIGITS = 6;
    localparam int DIGIT_IDX_W   = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W   = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NUMBER_NONBLANK  = 3'd0,
        REG_NUMBER_ALL       = 3'd1,
        REG_SQUEEZE_BLANK    = 3'd2,
        REG_SHOW_ENDS        = 3'd3,
        REG_SHOW_TABS        = 3'd4,
        REG_SHOW_NONPRINTING = 3'd5
    } cfg_reg_t;

    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NL        = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_QMARK     = 8'h3F;
    localparam logic [7:0] CH_I         = 8'h49;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_DEL       = 8'h7F;
    localparam logic [7:0] CTRL_MAX     = 8'd31;
    localparam logic [7:0] CARET_OFFSET = 8'd64;
    localparam logic [3:0] DIGIT_ASCII_HI = 4'h3;

    typedef logic [3:0] bcd_t;
    typedef bcd_t [NUMBER_DIGITS-1:0] count_t;

    localparam count_t COUNT_ONE = count_t'(1);

    typedef struct packed {
        logic       number;
        count_t     digits;
        logic       dollar;
        logic       esc;
        logic [7:0] ch;
    } cmd_t;

    typedef enum logic [2:0] {
        PH_NUM,
        PH_TAB,
        PH_END,
        PH_CARET,
        PH_CHAR
    } phase_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tlnef_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlnef_front
// Takes input beats, holds the options and the line state, and turns each
// byte that is not squeezed away into one output command for the queue.
// ----------------------------------------------------------------------------
module tlnef_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,
    input  logic                          s_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tlnef_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic                          cfg_data,
    output logic                          push,
    output tlnef_pkg::cmd_t               push_cmd,
    input  logic                          queue_full
);
    import tlnef_pkg::*;

    function automatic count_t count_inc(count_t c);
        count_t r;
        logic   carry;
        logic   full;
        r     = c;
        carry = 1'b1;
        full  = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            full = full & (c[i] == 4'd9);
        end
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (carry)
            begin
                if (c[i] == 4'd9)
                begin
                    r[i] = 4'd0;
                end
                else
                begin
                    r[i]  = c[i] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        if (full)
        begin
            r = c;
        end
        return r;
    endfunction

    function automatic logic bcd_ok(count_t c);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            ok = ok & (c[i] <= 4'd9);
        end
        return ok;
    endfunction

    logic   number_nonblank_reg;
    logic   number_all_reg;
    logic   squeeze_blank_reg;
    logic   show_ends_reg;
    logic   show_tabs_reg;
    logic   show_nonprinting_reg;

    logic   prev_newline_reg;
    logic   prev_newline_next;
    logic   squeeze_mark_reg;
    logic   squeeze_mark_next;
    count_t count_reg;
    count_t count_next;

    logic   accept;
    logic   is_nl;
    logic   eff_pn;
    logic   eff_sm;
    count_t eff_count;
    logic   drop;
    logic   number;

    assign s_tready  = !queue_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        is_nl     = (s_tdata == CH_NL);
        eff_pn    = s_tuser ? 1'b1 : prev_newline_reg;
        eff_sm    = s_tuser ? 1'b0 : squeeze_mark_reg;
        eff_count = s_tuser ? COUNT_ONE : count_reg;

        drop              = 1'b0;
        squeeze_mark_next = eff_sm;
        if (squeeze_blank_reg)
        begin
            if (is_nl && eff_pn)
            begin
                if (eff_sm)
                begin
                    drop = 1'b1;
                end
                squeeze_mark_next = 1'b1;
            end
            else
            begin
                squeeze_mark_next = 1'b0;
            end
        end

        if (number_nonblank_reg)
        begin
            number = eff_pn && !is_nl;
        end
        else
        begin
            number = number_all_reg && eff_pn;
        end

        prev_newline_next = drop ? eff_pn : is_nl;
        count_next        = (number && !drop) ? count_inc(eff_count) : eff_count;

        push_cmd.number = number;
        push_cmd.digits = eff_count;
        push_cmd.dollar = show_ends_reg && is_nl;
        push_cmd.esc    = 1'b0;
        push_cmd.ch     = s_tdata;
        if (show_tabs_reg && (s_tdata == CH_TAB))
        begin
            push_cmd.esc = 1'b1;
            push_cmd.ch  = CH_I;
        end
        else if (show_nonprinting_reg && (s_tdata <= CTRL_MAX) && (s_tdata != CH_TAB)
                 && !is_nl)
        begin
            push_cmd.esc = 1'b1;
            push_cmd.ch  = s_tdata + CARET_OFFSET;
        end
        else if (show_nonprinting_reg && (s_tdata == CH_DEL))
        begin
            push_cmd.esc = 1'b1;
            push_cmd.ch  = CH_QMARK;
        end

        push = accept && !drop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_nonblank_reg  <= 1'b0;
            number_all_reg       <= 1'b0;
            squeeze_blank_reg    <= 1'b0;
            show_ends_reg        <= 1'b0;
            show_tabs_reg        <= 1'b0;
            show_nonprinting_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_NUMBER_NONBLANK:  number_nonblank_reg  <= cfg_data;
                REG_NUMBER_ALL:       number_all_reg       <= cfg_data;
                REG_SQUEEZE_BLANK:    squeeze_blank_reg    <= cfg_data;
                REG_SHOW_ENDS:        show_ends_reg        <= cfg_data;
                REG_SHOW_TABS:        show_tabs_reg        <= cfg_data;
                REG_SHOW_NONPRINTING: show_nonprinting_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_newline_reg <= 1'b1;
            squeeze_mark_reg <= 1'b0;
            count_reg        <= COUNT_ONE;
        end
        else if (accept)
        begin
            prev_newline_reg <= prev_newline_next;
            squeeze_mark_reg <= squeeze_mark_next;
            count_reg        <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) bcd_ok(count_reg))
        else $error("Line counter holds a digit above nine.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !push) |-> squeeze_blank_reg)
        else $error("A byte was dropped while squeezing is off.");

endmodule
`default_nettype wire

// ===== hw/rtl/tlnef_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlnef_queue
// Short command queue between the classifying front and the output back.
// ----------------------------------------------------------------------------
module tlnef_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tlnef_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output tlnef_pkg::cmd_t head_cmd
);
    import tlnef_pkg::*;

    localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

    cmd_t                   mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QUEUE_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QUEUE_CNT_W'(1);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("Command queue holds more entries than its depth.");

endmodule
`default_nettype wire

// ===== hw/rtl/tlnef_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlnef_back
// Expands the command at the head of the queue into output bytes, one per
// cycle while the receiver takes them, through a registered output stage.
// ----------------------------------------------------------------------------
module tlnef_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  tlnef_pkg::cmd_t head_cmd,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);
    import tlnef_pkg::*;

    localparam logic [DIGIT_IDX_W-1:0] LAST_IDX = DIGIT_IDX_W'(NUMBER_DIGITS - 1);

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [DIGIT_IDX_W-1:0] idx_reg;
    logic [DIGIT_IDX_W-1:0] idx_next;
    logic                   fresh_reg;
    logic                   out_valid_reg;
    logic [7:0]             out_byte_reg;
    logic                   out_last_reg;

    phase_t                 cur_phase;
    logic [DIGIT_IDX_W-1:0] cur_idx;
    phase_t                 after_tab;
    logic                   adv;
    logic                   last_byte;
    logic [7:0]             cur_byte;
    logic [NUMBER_DIGITS-1:0] blank;
    logic                   zero_run;
    bcd_t                   cur_digit;

    assign adv = head_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        if (head_cmd.dollar)
        begin
            after_tab = PH_END;
        end
        else if (head_cmd.esc)
        begin
            after_tab = PH_CARET;
        end
        else
        begin
            after_tab = PH_CHAR;
        end

        if (fresh_reg)
        begin
            cur_phase = head_cmd.number ? PH_NUM : after_tab;
            cur_idx   = '0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_idx   = idx_reg;
        end
    end

    // Next state of the byte sequencer.
    always_comb
    begin
        phase_next = cur_phase;
        idx_next   = cur_idx;
        last_byte  = 1'b0;
        case (cur_phase)
            PH_NUM:
            begin
                if (cur_idx == LAST_IDX)
                begin
                    phase_next = PH_TAB;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = cur_idx + DIGIT_IDX_W'(1);
                end
            end
            PH_TAB:   phase_next = after_tab;
            PH_END:   phase_next = head_cmd.esc ? PH_CARET : PH_CHAR;
            PH_CARET: phase_next = PH_CHAR;
            PH_CHAR:  last_byte  = 1'b1;
            default:  last_byte  = 1'b1;
        endcase
    end

    // Byte produced in the current phase.
    always_comb
    begin
        zero_run = 1'b1;
        for (int p = 0; p < NUMBER_DIGITS; p++)
        begin
            zero_run = zero_run & (head_cmd.digits[NUMBER_DIGITS-1-p] == 4'd0);
            blank[p] = zero_run && (p != NUMBER_DIGITS - 1);
        end
        cur_digit = head_cmd.digits[LAST_IDX - cur_idx];

        case (cur_phase)
            PH_NUM:   cur_byte = blank[cur_idx] ? CH_SPACE : {DIGIT_ASCII_HI, cur_digit};
            PH_TAB:   cur_byte = CH_TAB;
            PH_END:   cur_byte = CH_DOLLAR;
            PH_CARET: cur_byte = CH_CARET;
            PH_CHAR:  cur_byte = head_cmd.ch;
            default:  cur_byte = head_cmd.ch;
        endcase
    end

    assign pop = adv && last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CHAR;
            idx_reg       <= '0;
            fresh_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
            out_last_reg  <= last_byte;
            fresh_reg     <= last_byte;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_byte_reg <= cur_byte;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n) pop |=> (fresh_reg && m_tlast))
        else $error("Command retired without closing its run.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !last_byte) |=> (!fresh_reg && !m_tlast))
        else $error("Run closed before its command was complete.");

endmodule
`default_nettype wire

// ===== hw/rtl/text_line_number_escape_filter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_line_number_escape_filter_unit
// Byte stream filter that numbers lines, squeezes blank lines and shows
// line ends, tabs and control bytes in caret notation.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while the two-entry command queue has
// room. Each input byte yields zero to nine output bytes (six number digits
// and a tab, then a dollar sign and the newline or a two-byte caret escape).
// The sequencer sends one byte per cycle while the receiver is ready and
// finishes an input byte's expansion before the next; plain bytes flow at one
// per cycle while the receiver is ready. A squeezed blank line gives no output beat.
// m_tlast marks the final output byte caused by each input beat. The user must
// write options on the cfg channel only while no beat is in flight; not enforced by the block.
// ----------------------------------------------------------------------------
module text_line_number_escape_filter_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] text_byte
    input  logic                              s_tuser,   // [0] first_of_file
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] out_byte
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tlnef_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic                              cfg_data
);
    import tlnef_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    tlnef_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    tlnef_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    tlnef_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for text_line_number_escape_filter_unit
// Sends text bytes through the line number and escape filter and checks
// every output beat against a behavioral prediction of the filter. The
// stimulus has directed bytes, option settings and random text lines. The
// run covers random idling on both sides, a long output stall and blank line
// squeezing, and numbering over a run of empty lines.
// ----------------------------------------------------------------------------
module testbench;

    import tlnef_pkg::*;

    localparam int          CLK_HALF       = 6;
    localparam int          RESET_CYCLES   = 10;
    localparam int          SETTLE_CYCLES  = 20;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WIDE_LINES     = 12;
    localparam int          CHUNK_BYTES    = 15;
    localparam longint      RUN_LIMIT      = 64'd6_000_000;
    localparam int unsigned LINE_NO_MAX    = 10 ** NUMBER_DIGITS - 1;
    localparam logic [7:0]  CH_ZERO        = "0";
    localparam logic [7:0]  CH_LETTER_A    = "A";
    localparam logic [7:0]  CH_LETTER_X    = "x";
    localparam logic [7:0]  CH_LOWER_A     = "a";
    localparam logic [7:0]  CH_TILDE       = "~";
    localparam logic [7:0]  CH_NUL         = 8'h00;
    localparam logic [7:0]  CH_SOH         = 8'h01;
    localparam logic [7:0]  CH_US          = 8'h1F;
    localparam logic [7:0]  CH_HIGH_FIRST  = 8'h80;
    localparam logic [7:0]  CH_HIGH_LAST   = 8'hFF;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_beat_t;

    logic                   clk;
    logic                   rst_n      = 1'b0;
    logic                   s_tvalid   = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata    = '0;
    logic                   s_tuser    = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready   = 1'b0;
    logic [7:0]             m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid  = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic                   cfg_data   = 1'b0;

    out_beat_t   formatted_q[$];
    int          error_count     = 0;
    int          bytes_taken     = 0;
    int          beats_checked   = 0;
    int          settings_used   = 0;
    int          tx_idle_pct     = 0;
    int          rx_idle_pct     = 0;
    int          rx_hold_left    = 0;

    logic        opt_nonblank    = 1'b0;
    logic        opt_all         = 1'b0;
    logic        opt_squeeze     = 1'b0;
    logic        opt_ends        = 1'b0;
    logic        opt_tabs        = 1'b0;
    logic        opt_nonprint    = 1'b0;
    logic        at_line_start   = 1'b1;
    logic        blank_let_pass  = 1'b0;
    int unsigned line_no         = 1;

    text_line_number_escape_filter_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("text_line_number_escape_filter_unit test failed");
        $finish;
    end

    function automatic void apply_option(input logic [CFG_INDEX_W-1:0] idx, input logic d);
        case (cfg_reg_t'(idx))
            REG_NUMBER_NONBLANK:  opt_nonblank = d;
            REG_NUMBER_ALL:       opt_all      = d;
            REG_SQUEEZE_BLANK:    opt_squeeze  = d;
            REG_SHOW_ENDS:        opt_ends     = d;
            REG_SHOW_TABS:        opt_tabs     = d;
            REG_SHOW_NONPRINTING: opt_nonprint = d;
            default: ;
        endcase
    endfunction

    function automatic void push_line_number(ref out_beat_t run[$]);
        logic [7:0]  digit_chars[NUMBER_DIGITS];
        int unsigned rest;
        rest = line_no;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--)
        begin
            if (rest == 0 && i != NUMBER_DIGITS - 1)
                digit_chars[i] = CH_SPACE;
            else
            begin
                digit_chars[i] = CH_ZERO + 8'(rest % 10);
                rest = rest / 10;
            end
        end
        for (int i = 0; i < NUMBER_DIGITS; i++)
            run.push_back('{ch: digit_chars[i], last: 1'b0});
        run.push_back('{ch: CH_TAB, last: 1'b0});
        if (line_no < LINE_NO_MAX)
            line_no++;
    endfunction

    // Works out the output beats that one accepted text byte causes.
    function automatic void format_text_byte(input logic [7:0] b, input logic first_of_file);
        out_beat_t run[$];
        logic      is_nl;
        is_nl = (b == CH_NL);
        if (first_of_file)
        begin
            line_no        = 1;
            at_line_start  = 1'b1;
            blank_let_pass = 1'b0;
        end
        if (opt_squeeze)
        begin
            if (is_nl && at_line_start)
            begin
                if (blank_let_pass)
                    return;
                blank_let_pass = 1'b1;
            end
            else
                blank_let_pass = 1'b0;
        end
        if (opt_nonblank)
        begin
            if (at_line_start && !is_nl)
                push_line_number(run);
        end
        else if (opt_all && at_line_start)
            push_line_number(run);
        if (opt_ends && is_nl)
            run.push_back('{ch: CH_DOLLAR, last: 1'b0});
        if (opt_tabs && b == CH_TAB)
        begin
            run.push_back('{ch: CH_CARET, last: 1'b0});
            run.push_back('{ch: CH_I, last: 1'b0});
        end
        else if (opt_nonprint && b <= CTRL_MAX && b != CH_TAB && !is_nl)
        begin
            run.push_back('{ch: CH_CARET, last: 1'b0});
            run.push_back('{ch: b + CARET_OFFSET, last: 1'b0});
        end
        else if (opt_nonprint && b == CH_DEL)
        begin
            run.push_back('{ch: CH_CARET, last: 1'b0});
            run.push_back('{ch: CH_QMARK, last: 1'b0});
        end
        else
            run.push_back('{ch: b, last: 1'b0});
        at_line_start = is_nl;
        run[run.size() - 1].last = 1'b1;
        foreach (run[i])
            formatted_q.push_back(run[i]);
    endfunction

    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_option(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
            begin
                format_text_byte(s_tdata, s_tuser);
                bytes_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                beats_checked++;
                if (formatted_q.size() == 0)
                begin
                    $display("%0t: unexpected output beat: expected none, actual byte %h last %b",
                             $time, m_tdata, m_tlast);
                    error_count++;
                end
                else
                begin
                    want = formatted_q.pop_front();
                    if (m_tdata !== want.ch)
                    begin
                        $display("%0t: out_byte mismatch: expected %h, actual %h",
                                 $time, want.ch, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $display("%0t: last_of_run mismatch: expected %b, actual %b",
                                 $time, want.last, m_tlast);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold_left > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_text_byte(input logic [7:0] b, input logic first_of_file);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first_of_file;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain_output();
        s_tvalid <= 1'b0;
        while (formatted_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_option(input logic [CFG_INDEX_W-1:0] idx, input logic d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_options(input logic nonblank, input logic all_lines,
                               input logic squeeze, input logic ends,
                               input logic tabs, input logic nonprint);
        write_option(REG_NUMBER_NONBLANK, nonblank);
        write_option(REG_NUMBER_ALL, all_lines);
        write_option(REG_SQUEEZE_BLANK, squeeze);
        write_option(REG_SHOW_ENDS, ends);
        write_option(REG_SHOW_TABS, tabs);
        write_option(REG_SHOW_NONPRINTING, nonprint);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [7:0] pick_text_byte();
        case ($urandom_range(9))
            0, 1, 2: return 8'($urandom_range(CH_SPACE, CH_TILDE));
            3:       return CH_TAB;
            4:       return 8'($urandom_range(CTRL_MAX));
            5:       return CH_DEL;
            6:       return 8'($urandom_range(CH_HIGH_FIRST, CH_HIGH_LAST));
            7:       return 8'($urandom_range(CH_HIGH_LAST));
            default: return 8'($urandom_range(CH_LOWER_A, CH_LOWER_A + 8'd25));
        endcase
    endfunction

    task automatic send_random_lines(input int n);
        int sent;
        int line_len;
        sent = 0;
        while (sent < n)
        begin
            line_len = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 7);
            for (int j = 0; j < line_len && sent < n; j++)
            begin
                send_text_byte(pick_text_byte(), $urandom_range(99) < 3);
                sent++;
            end
            if (sent < n)
            begin
                send_text_byte(CH_NL, $urandom_range(99) < 3);
                sent++;
            end
        end
    endtask

    task automatic test_plain_bytes();
        send_text_byte(CH_NUL, 1'b1);
        send_text_byte(CH_HIGH_LAST, 1'b0);
        send_text_byte(CH_HIGH_FIRST, 1'b0);
        send_text_byte(CH_DEL, 1'b0);
        send_text_byte(CH_TAB, 1'b0);
        send_text_byte(CH_NL, 1'b0);
        send_text_byte(CH_LETTER_A, 1'b0);
    endtask

    task automatic test_escapes_and_numbering();
        drain_output();
        set_options(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        write_option(REG_UNUSED_6, 1'b1);
        write_option(REG_UNUSED_7, 1'b1);
        cfg_valid <= 1'b0;
        send_text_byte(CH_LOWER_A, 1'b1);
        send_text_byte(CH_TAB, 1'b0);
        send_text_byte(CH_SOH, 1'b0);
        send_text_byte(CH_DEL, 1'b0);
        send_text_byte(CH_US, 1'b0);
        send_text_byte(CH_NL, 1'b0);
        send_text_byte(CH_NL, 1'b0);
        send_text_byte(CH_NL, 1'b0);
        send_text_byte(CH_NL, 1'b0);
        send_text_byte(CH_HIGH_FIRST, 1'b0);
        send_text_byte(CH_HIGH_LAST, 1'b0);
        send_text_byte(CH_NL, 1'b0);
        drain_output();
        set_options(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
        send_text_byte(CH_NL, 1'b1);
        send_text_byte(CH_LETTER_X, 1'b0);
        send_text_byte(CH_NL, 1'b0);
        send_text_byte(CH_NL, 1'b0);
        send_text_byte(CH_NUL, 1'b0);
        send_text_byte(CH_NL, 1'b0);
    endtask

    task automatic test_random_text(input int chunks, input int per_chunk);
        for (int c = 0; c < chunks; c++)
        begin
            drain_output();
            set_options(1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
            send_random_lines(per_chunk);
        end
    endtask

    // The receiver stalls long enough for the command queue to fill, so the
    // input side has to back up while the sender keeps offering bytes.
    task automatic test_output_hold_off();
        drain_output();
        set_options(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        rx_hold_left = HOLD_CYCLES;
        send_random_lines(20);
        drain_output();
    endtask

    task automatic test_wide_line_numbers();
        drain_output();
        set_options(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_text_byte(CH_NL, 1'b1);
        for (int i = 1; i < WIDE_LINES; i++)
            send_text_byte(CH_NL, 1'b0);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 14;
        rx_idle_pct = 55;
        test_plain_bytes();
        test_escapes_and_numbering();
        test_random_text(3, CHUNK_BYTES);

        tx_idle_pct = 55;
        rx_idle_pct = 14;
        test_output_hold_off();
        test_random_text(2, CHUNK_BYTES);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_wide_line_numbers();
        test_random_text(2, CHUNK_BYTES);

        drain_output();
        $display("Run covered %0d input bytes and %0d output beats under %0d option settings,",
                 bytes_taken, beats_checked, settings_used);
        $display("including squeezed blank lines, caret escapes, a long output stall "
                 , "and a run of %0d numbered empty lines.", WIDE_LINES);
        if (error_count == 0)
            $display("text_line_number_escape_filter_unit test passed");
        else
            $display("text_line_number_escape_filter_unit test failed");
        $finish;
    end

endmodule
